### rtl/core/mrs_pkg.sv
// Shared types and constants for the Modbus RTU slave engine.
// Used by every module under rtl/core; no dependencies of its own.
package mrs_pkg;

  // Parameter defaults.
  localparam int REGS_PER_BANK_DEF = 32;
  localparam int FRAME_DEPTH_DEF   = 128;
  localparam int MAX_READ_REGS_DEF = 29;
  localparam int READ_BANKS_DEF    = 4;

  // CRC-16/Modbus, reflected.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam int          CRC_BITS = 8;

  // Protocol constants.
  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_WRITE_COIL = 8'h0F;
  localparam logic [7:0] FC_WRITE_MULT = 8'h10;
  localparam logic [7:0] EXC_FLAG      = 8'h80;
  localparam int         BASE_LEN      = 8;
  localparam int         EXT_LEN_ADD   = 9;
  localparam int         HDR_BYTES     = 7;
  localparam int         DATA_START    = 7;
  localparam int         WR_MAX_QTY    = 123;
  localparam int         WR_REPLY_LAST = 5;
  localparam int         EXC_REPLY_LAST = 2;
  localparam int         LEN_W         = 10;

  typedef enum logic [1:0] {
    FUNC_LINE = 2'd0,
    FUNC_LOAD = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_HOST = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EXC_NONE  = 2'd0,
    EXC_FUNC  = 2'd1,
    EXC_ADDR  = 2'd2,
    EXC_VALUE = 2'd3
  } exc_t;

  typedef enum logic [1:0] {
    MODE_READ,
    MODE_WRITE,
    MODE_EXC
  } mode_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_RXCRC,
    ST_RXCHK,
    ST_EVAL,
    ST_DROP,
    ST_HWAIT,
    ST_HEMIT,
    ST_WH_A,
    ST_WH_B,
    ST_WL_A,
    ST_WL_B,
    ST_BYTE,
    ST_CALC,
    ST_CRCW,
    ST_EMIT,
    ST_TLO,
    ST_THI
  } state_t;

endpackage

### rtl/core/mrs_crc.sv
// Bit-serial CRC-16/Modbus unit: folds one byte into the CRC, one bit a cycle.
// Depends on mrs_pkg for the polynomial and the bit count.
module mrs_crc import mrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] init,
  input  logic [7:0]  data,
  output logic        busy,
  output logic [15:0] crc
);

  logic [3:0] cnt;

  assign busy = (cnt != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
    end else if (start) begin
      cnt <= 4'(CRC_BITS);
    end else if (busy) begin
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      crc <= init ^ {8'd0, data};
    end else if (busy) begin
      crc <= crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
  end

endmodule

### rtl/core/modbus_rtu_slave_engine.sv
// Top level of the Modbus RTU slave engine: frame capture, request decode,
// register banks and reply sequencer. Depends on mrs_pkg and mrs_crc.
//
//   channel  direction  handshake              payload
//   in       into block in_valid / in_stall     func rx_byte bank reg_index word
//   out      from block out_valid / out_stall   kind tx_byte tx_last
//                                              exception_code read_word
//
// A line byte passes through the bit-serial CRC unit and the frame check
// before the next byte is taken; each reply byte passes through the same CRC
// unit, and each written register of function 0x10 takes two frame store reads.
// Host loads are written from ST_IDLE; host reads pass ST_HWAIT and ST_HEMIT.
// After reset a clearing pass loads the banks before in_stall drops.
// out_stall only holds the output register; the sequencer waits for it.
module modbus_rtu_slave_engine import mrs_pkg::*; #(
  parameter int REGS_PER_BANK = REGS_PER_BANK_DEF,
  parameter int FRAME_DEPTH   = FRAME_DEPTH_DEF,
  parameter int MAX_READ_REGS = MAX_READ_REGS_DEF,
  parameter int READ_BANKS    = READ_BANKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [1:0]  bank,
  input  logic [4:0]  reg_index,
  input  logic [15:0] word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [1:0]  exception_code,
  output logic [15:0] read_word
);

  localparam int RB_N   = READ_BANKS * REGS_PER_BANK;
  localparam int RB_AW  = (RB_N > 1) ? $clog2(RB_N) : 1;
  localparam int WB_AW  = (REGS_PER_BANK > 1) ? $clog2(REGS_PER_BANK) : 1;
  localparam int FS_AW  = $clog2(FRAME_DEPTH);
  localparam int BC_W   = $clog2(FRAME_DEPTH + 1);
  localparam int TXP_W  = $clog2(2 * MAX_READ_REGS + 3);
  localparam int WI_MAX = (MAX_READ_REGS > REGS_PER_BANK) ? MAX_READ_REGS : REGS_PER_BANK;
  localparam int WI_W   = $clog2(WI_MAX + 1);

  state_t state, state_next;

  // Frame receive state.
  logic [BC_W-1:0]  byte_count;
  logic [LEN_W-1:0] expected;
  logic [7:0]       hdr [HDR_BYTES];

  // Request decode results.
  mode_t             mode;
  exc_t              exc;
  logic [TXP_W-1:0]  last_pos;
  logic [TXP_W-1:0]  tx_pos;
  logic [RB_AW-1:0]  rbase;
  logic [WB_AW-1:0]  wbase;
  logic [WI_W-1:0]   qty_r;
  logic [WI_W-1:0]   wi;
  logic [FS_AW-1:0]  fptr;
  logic [7:0]        hi_byte;
  logic [7:0]        txb;
  logic [4:0]        hidx;
  logic [RB_AW-1:0]  clr;

  // Memories.
  logic [7:0]  fs [FRAME_DEPTH];
  logic [7:0]  fs_q;
  logic [15:0] rb [RB_N];
  logic [15:0] rb_q;
  logic [15:0] wb [REGS_PER_BANK];
  logic [15:0] wb_q;

  // CRC unit.
  logic        crc_start, crc_busy;
  logic [15:0] crc_init, crc;
  logic [7:0]  crc_data;

  // Control.
  logic        in_acc, rx_acc, load_acc;
  logic        slot;
  logic        ld;
  kind_t       ld_kind;
  logic [7:0]  ld_byte;
  logic        ld_last;
  exc_t        ld_exc;
  logic [15:0] ld_word;
  logic [7:0]  tx_sel;

  // Frame end check.
  logic             ext, over, done;
  logic [LEN_W-1:0] exp_eff;

  // Decode.
  logic [15:0]      qty;
  mode_t            ev_mode;
  exc_t             ev_exc;
  logic [TXP_W-1:0] ev_last;

  logic [RB_AW-1:0] rb_raddr;
  logic [RB_AW-1:0] rb_haddr;
  logic [WB_AW-1:0] wb_waddr;
  logic             wb_wr;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && (state == ST_IDLE);
  assign rx_acc   = in_acc && (func == FUNC_LINE);
  assign load_acc = in_acc && (func == FUNC_LOAD) && (32'(bank) < READ_BANKS)
                    && (32'(reg_index) < REGS_PER_BANK);
  assign slot     = !out_valid || !out_stall;

  assign rb_haddr = RB_AW'(32'(bank) * 32'(REGS_PER_BANK) + 32'(reg_index));
  assign rb_raddr = RB_AW'(32'(rbase) + 32'(wi));
  assign wb_waddr = WB_AW'(32'(wbase) + 32'(wi));
  assign wb_wr    = (state == ST_WL_B);

  mrs_crc u_crc (
    .clk   (clk),
    .rst   (rst),
    .start (crc_start),
    .init  (crc_init),
    .data  (crc_data),
    .busy  (crc_busy),
    .crc   (crc)
  );

  // Frame length check once the CRC of the latest byte has settled.
  assign qty = {hdr[4], hdr[5]};
  always_comb begin
    ext = (byte_count == BC_W'(HDR_BYTES))
          && ((hdr[1] == FC_WRITE_COIL) || (hdr[1] == FC_WRITE_MULT));
    exp_eff = ext ? (LEN_W'(hdr[6]) + LEN_W'(EXT_LEN_ADD)) : expected;
    over = ext && (exp_eff > LEN_W'(FRAME_DEPTH));
    done = (LEN_W'(byte_count) >= exp_eff);
  end

  // Request decode.
  always_comb begin
    ev_mode = MODE_EXC;
    ev_exc  = EXC_FUNC;
    ev_last = TXP_W'(EXC_REPLY_LAST);
    if (hdr[1] == FC_READ_HOLD) begin
      if ((qty == 16'd0) || (32'(qty) > MAX_READ_REGS)) begin
        ev_exc = EXC_VALUE;
      end else if ((32'(hdr[2]) >= READ_BANKS)
                   || (32'(hdr[3]) + 32'(qty) > REGS_PER_BANK)) begin
        ev_exc = EXC_ADDR;
      end else begin
        ev_mode = MODE_READ;
        ev_exc  = EXC_NONE;
        ev_last = TXP_W'({qty, 1'b0} + 17'd2);
      end
    end else if (hdr[1] == FC_WRITE_MULT) begin
      if ((qty == 16'd0) || (32'(qty) > WR_MAX_QTY) || (17'(hdr[6]) != {qty, 1'b0})) begin
        ev_exc = EXC_VALUE;
      end else if (32'({hdr[2], hdr[3]}) + 32'(qty) > REGS_PER_BANK) begin
        ev_exc = EXC_ADDR;
      end else begin
        ev_mode = MODE_WRITE;
        ev_exc  = EXC_NONE;
        ev_last = TXP_W'(WR_REPLY_LAST);
      end
    end
  end

  // Reply byte at the current position.
  always_comb begin
    unique case (mode)
      MODE_EXC: begin
        if (tx_pos == TXP_W'(0)) begin
          tx_sel = hdr[0];
        end else if (tx_pos == TXP_W'(1)) begin
          tx_sel = hdr[1] | EXC_FLAG;
        end else begin
          tx_sel = {6'd0, exc};
        end
      end
      MODE_WRITE: tx_sel = hdr[3'(tx_pos)];
      MODE_READ: begin
        if (tx_pos == TXP_W'(0)) begin
          tx_sel = hdr[0];
        end else if (tx_pos == TXP_W'(1)) begin
          tx_sel = hdr[1];
        end else if (tx_pos == TXP_W'(2)) begin
          tx_sel = 8'({qty_r, 1'b0});
        end else begin
          // Data starts at an odd position, high byte first.
          tx_sel = tx_pos[0] ? rb_q[15:8] : rb_q[7:0];
        end
      end
      default: tx_sel = hdr[0];
    endcase
  end

  always_comb begin
    crc_start = rx_acc || (state == ST_CALC);
    if (state == ST_CALC) begin
      crc_data = tx_sel;
      crc_init = (tx_pos == TXP_W'(0)) ? CRC_INIT : crc;
    end else begin
      crc_data = rx_byte;
      crc_init = (byte_count == BC_W'(0)) ? CRC_INIT : crc;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ld      = 1'b0;
    ld_kind = KIND_TX;
    ld_byte = 8'd0;
    ld_last = 1'b0;
    ld_exc  = EXC_NONE;
    ld_word = 16'd0;
    unique case (state)
      ST_INIT: begin
        if (clr == RB_AW'(RB_N - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_LINE) begin
            state_next = ST_RXCRC;
          end else if (func == FUNC_READ) begin
            state_next = ST_HWAIT;
          end
        end
      end
      ST_RXCRC: begin
        if (!crc_busy) state_next = ST_RXCHK;
      end
      ST_RXCHK: begin
        priority if (over) begin
          state_next = ST_DROP;
        end else if (done) begin
          state_next = (crc != 16'd0) ? ST_DROP : ST_EVAL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EVAL: state_next = (ev_mode == MODE_WRITE) ? ST_WH_A : ST_BYTE;
      ST_DROP: begin
        if (slot) begin
          ld         = 1'b1;
          ld_kind    = KIND_DROP;
          ld_last    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_HWAIT: state_next = ST_HEMIT;
      ST_HEMIT: begin
        if (slot) begin
          ld         = 1'b1;
          ld_kind    = KIND_HOST;
          ld_last    = 1'b1;
          ld_word    = (32'(hidx) < REGS_PER_BANK) ? wb_q : 16'd0;
          state_next = ST_IDLE;
        end
      end
      ST_WH_A: state_next = ST_WH_B;
      ST_WH_B: state_next = ST_WL_A;
      ST_WL_A: state_next = ST_WL_B;
      ST_WL_B: state_next = (wi == qty_r - WI_W'(1)) ? ST_BYTE : ST_WH_A;
      ST_BYTE: state_next = ST_CALC;
      ST_CALC: state_next = ST_CRCW;
      ST_CRCW: begin
        if (!crc_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot) begin
          ld         = 1'b1;
          ld_byte    = txb;
          ld_exc     = exc;
          state_next = (tx_pos == last_pos) ? ST_TLO : ST_BYTE;
        end
      end
      ST_TLO: begin
        if (slot) begin
          ld         = 1'b1;
          ld_byte    = crc[7:0];
          ld_exc     = exc;
          state_next = ST_THI;
        end
      end
      ST_THI: begin
        if (slot) begin
          ld         = 1'b1;
          ld_byte    = crc[15:8];
          ld_last    = 1'b1;
          ld_exc     = exc;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      expected   <= LEN_W'(BASE_LEN);
      clr        <= '0;
    end else begin
      if (state == ST_INIT) clr <= clr + RB_AW'(1);
      if (rx_acc) byte_count <= byte_count + BC_W'(1);
      if (state == ST_RXCHK) begin
        if (over || done) begin
          byte_count <= '0;
          expected   <= LEN_W'(BASE_LEN);
        end else begin
          expected <= exp_eff;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rx_acc && (byte_count < BC_W'(HDR_BYTES))) hdr[3'(byte_count)] <= rx_byte;
    if (in_acc) hidx <= reg_index;
    unique case (state)
      ST_EVAL: begin
        mode     <= ev_mode;
        exc      <= ev_exc;
        last_pos <= ev_last;
        rbase    <= RB_AW'(32'(hdr[2]) * 32'(REGS_PER_BANK) + 32'(hdr[3]));
        wbase    <= WB_AW'({hdr[2], hdr[3]});
        qty_r    <= WI_W'(qty);
        wi       <= '0;
        tx_pos   <= '0;
        fptr     <= FS_AW'(DATA_START);
      end
      ST_WH_B: begin
        hi_byte <= fs_q;
        fptr    <= fptr + FS_AW'(1);
      end
      ST_WL_B: begin
        fptr <= fptr + FS_AW'(1);
        wi   <= (wi == qty_r - WI_W'(1)) ? '0 : wi + WI_W'(1);
      end
      ST_CALC: txb <= tx_sel;
      ST_EMIT: begin
        if (slot && (tx_pos != last_pos)) begin
          tx_pos <= tx_pos + TXP_W'(1);
          // Move to the next word after its low byte.
          if ((mode == MODE_READ) && (tx_pos > TXP_W'(2)) && !tx_pos[0]) begin
            wi <= wi + WI_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Frame store.
  always_ff @(posedge clk) begin
    if (rx_acc && (32'(byte_count) < FRAME_DEPTH)) fs[FS_AW'(byte_count)] <= rx_byte;
    fs_q <= fs[fptr];
  end

  // Read banks: the clearing pass writes bank zero with 1 upward, others 0.
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      rb[clr] <= (32'(clr) < REGS_PER_BANK) ? 16'(32'(clr) + 1) : 16'd0;
    end else if (load_acc) begin
      rb[rb_haddr] <= word;
    end
    rb_q <= rb[rb_raddr];
  end

  // Write bank: the clearing pass writes REGS_PER_BANK downward.
  always_ff @(posedge clk) begin
    if ((state == ST_INIT) && (32'(clr) < REGS_PER_BANK)) begin
      wb[WB_AW'(clr)] <= 16'(REGS_PER_BANK - 32'(clr));
    end else if (wb_wr) begin
      wb[wb_waddr] <= {hi_byte, fs_q};
    end
    wb_q <= wb[WB_AW'(hidx)];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      kind           <= ld_kind;
      tx_byte        <= ld_byte;
      tx_last        <= ld_last;
      exception_code <= ld_exc;
      read_word      <= ld_word;
    end
  end

endmodule
